@@ design/csp_pkg.sv @@
package csp_pkg;

    localparam int LINE_BITS     = 24;
    localparam int COUNT_BITS    = 32;
    localparam int MAX_RES       = 6;
    localparam int RES_IDX_BITS  = $clog2(MAX_RES);
    localparam int RES_CNT_BITS  = $clog2(MAX_RES + 1);
    localparam int TOK_SLOTS     = 8;
    localparam int TOK_IDX_BITS  = $clog2(TOK_SLOTS);

    typedef logic [7:0] char_t;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_NL     = 8'h0A;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_BANG   = 8'h21;
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_HASH   = 8'h23;
    localparam char_t CH_SQUOTE = 8'h27;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_LT     = 8'h3C;
    localparam char_t CH_EQ     = 8'h3D;
    localparam char_t CH_GT     = 8'h3E;
    localparam char_t CH_QUEST  = 8'h3F;
    localparam char_t CH_LBRACK = 8'h5B;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_RBRACK = 8'h5D;
    localparam char_t CH_CARET  = 8'h5E;
    localparam char_t CH_LBRACE = 8'h7B;
    localparam char_t CH_VBAR   = 8'h7C;
    localparam char_t CH_RBRACE = 8'h7D;
    localparam char_t CH_TILDE  = 8'h7E;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // character handed to the comment scanner, or a removed splice
    typedef struct packed {
        logic  valid;
        logic  splice;
        char_t ch;
    } token_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        char_t ch;
    } event_t;

    typedef struct packed {
        kind_t                 kind;
        char_t                 ch;
        logic [LINE_BITS-1:0]  line;
        logic [COUNT_BITS-1:0] count;
    } result_t;

    // zero when the byte does not complete a trigraph
    function automatic char_t trigraph_map(input char_t c);
        char_t t;
        case (c)
            CH_LPAREN: t = CH_LBRACK;
            CH_RPAREN: t = CH_RBRACK;
            CH_LT:     t = CH_LBRACE;
            CH_GT:     t = CH_RBRACE;
            CH_EQ:     t = CH_HASH;
            CH_SLASH:  t = CH_BSLASH;
            CH_SQUOTE: t = CH_CARET;
            CH_BANG:   t = CH_VBAR;
            CH_MINUS:  t = CH_TILDE;
            default:   t = CH_NUL;
        endcase
        return t;
    endfunction

    function automatic logic [LINE_BITS-1:0] line_add(input logic [LINE_BITS-1:0] v,
                                                      input logic [RES_CNT_BITS-1:0] k);
        logic [LINE_BITS:0] s;
        s = {1'b0, v} + {{(LINE_BITS + 1 - RES_CNT_BITS){1'b0}}, k};
        return s[LINE_BITS] ? {LINE_BITS{1'b1}} : s[LINE_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_add(input logic [COUNT_BITS-1:0] v,
                                                        input logic [RES_CNT_BITS-1:0] k);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + {{(COUNT_BITS + 1 - RES_CNT_BITS){1'b0}}, k};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

endpackage

@@ design/csp_front.sv @@
// Trigraph replacement and backslash-newline splicing.
module csp_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  logic                                    flush,
    input  csp_pkg::char_t                          in_byte,
    output csp_pkg::token_t [csp_pkg::TOK_SLOTS-1:0] tok
);
    import csp_pkg::*;

    logic                     held_bs_reg;
    logic                     held_bs_next;
    logic [1:0]               held_q_reg;
    logic [1:0]               held_q_next;

    char_t                    trig;
    char_t [3:0]              ent;
    logic  [3:0]              ent_v;
    logic  [1:0]              k;
    logic  [1:0]              q;
    logic                     bs;
    logic                     done;
    logic  [TOK_IDX_BITS-1:0] j;

    assign trig = trigraph_map(in_byte);

    always_comb
    begin
        ent   = '0;
        ent_v = '0;
        k     = '0;
        q     = held_q_reg;
        if (held_q_reg == 2'd2)
        begin
            if (trig != CH_NUL)
            begin
                q        = 2'd0;
                ent[k]   = trig;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
            end
            else if (in_byte == CH_QUEST)
            begin
                // three in a row: oldest goes out, two stay held
                ent[k]   = CH_QUEST;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
            end
            else
            begin
                q        = 2'd0;
                ent[k]   = CH_QUEST;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
                ent[k]   = CH_QUEST;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
                ent[k]   = in_byte;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
            end
        end
        else if (held_q_reg == 2'd1)
        begin
            if (in_byte == CH_QUEST)
            begin
                q = 2'd2;
            end
            else
            begin
                q        = 2'd0;
                ent[k]   = CH_QUEST;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
                ent[k]   = in_byte;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
            end
        end
        else
        begin
            if (in_byte == CH_QUEST)
            begin
                q = 2'd1;
            end
            else
            begin
                ent[k]   = in_byte;
                ent_v[k] = 1'b1;
                k        = k + 2'd1;
            end
        end
        if (flush && q != 2'd0)
        begin
            ent[k]   = CH_QUEST;
            ent_v[k] = 1'b1;
            k        = k + 2'd1;
        end
        if (flush && q == 2'd2)
        begin
            ent[k]   = CH_QUEST;
            ent_v[k] = 1'b1;
        end
    end

    always_comb
    begin
        tok = '0;
        bs  = held_bs_reg;
        j   = '0;
        for (int i = 0; i < 4; i++)
        begin
            done = 1'b0;
            if (ent_v[i])
            begin
                if (bs)
                begin
                    bs = 1'b0;
                    if (ent[i] == CH_NL)
                    begin
                        tok[j] = '{valid: 1'b1, splice: 1'b1, ch: CH_NUL};
                        j      = j + 1'b1;
                        done   = 1'b1;
                    end
                    else
                    begin
                        tok[j] = '{valid: 1'b1, splice: 1'b0, ch: CH_BSLASH};
                        j      = j + 1'b1;
                    end
                end
                if (!done)
                begin
                    if (ent[i] == CH_BSLASH)
                    begin
                        bs = 1'b1;
                    end
                    else
                    begin
                        tok[j] = '{valid: 1'b1, splice: 1'b0, ch: ent[i]};
                        j      = j + 1'b1;
                    end
                end
            end
        end
        if (flush && bs)
        begin
            tok[j] = '{valid: 1'b1, splice: 1'b0, ch: CH_BSLASH};
            bs     = 1'b0;
        end
        held_bs_next = flush ? 1'b0 : bs;
        held_q_next  = flush ? 2'd0 : q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bs_reg <= 1'b0;
            held_q_reg  <= 2'd0;
        end
        else if (step)
        begin
            held_bs_reg <= held_bs_next;
            held_q_reg  <= held_q_next;
        end
    end

endmodule

@@ design/csp_scan.sv @@
// Comment stripping and literal tracking over the spliced character stream.
module csp_scan (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          step,
    input  logic                                          flush,
    input  csp_pkg::token_t [csp_pkg::TOK_SLOTS-1:0]      tok,
    output csp_pkg::event_t [csp_pkg::MAX_RES-1:0]        ev,
    output logic [csp_pkg::RES_CNT_BITS-1:0]              ev_count
);
    import csp_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4,
        MODE_LIT    = 3'd5,
        MODE_ESC    = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_DOUBLE = 2'd1,
        QUOTE_SINGLE = 2'd2
    } quote_t;

    typedef struct packed {
        mode_t  mode;
        quote_t quote;
        logic   emit;
    } norm_t;

    function automatic norm_t scan_normal(input char_t c, input quote_t qk);
        norm_t r;
        r.mode  = MODE_NORMAL;
        r.quote = qk;
        r.emit  = 1'b1;
        if (c == CH_SLASH)
        begin
            r.mode = MODE_SLASH;
            r.emit = 1'b0;
        end
        else if (c == CH_DQUOTE)
        begin
            r.mode  = MODE_LIT;
            r.quote = QUOTE_DOUBLE;
        end
        else if (c == CH_SQUOTE)
        begin
            r.mode  = MODE_LIT;
            r.quote = QUOTE_SINGLE;
        end
        return r;
    endfunction

    mode_t                   mode_reg;
    mode_t                   mode_next;
    quote_t                  quote_reg;
    quote_t                  quote_next;

    mode_t                   mode;
    quote_t                  quote;
    norm_t                   nr;
    char_t                   c;
    char_t                   e0;
    char_t                   e1;
    logic                    e0_v;
    logic                    e1_v;
    logic                    rm;
    logic                    tail_v;
    char_t                   tail;
    logic [RES_CNT_BITS-1:0] n;

    always_comb
    begin
        mode  = mode_reg;
        quote = quote_reg;
        ev    = '0;
        n     = '0;
        for (int i = 0; i < TOK_SLOTS; i++)
        begin
            e0_v = 1'b0;
            e1_v = 1'b0;
            e0   = CH_NUL;
            e1   = CH_NUL;
            rm   = 1'b0;
            c    = tok[i].ch;
            nr   = scan_normal(tok[i].ch, quote);
            if (tok[i].valid)
            begin
                if (tok[i].splice)
                begin
                    rm = 1'b1;
                end
                else
                begin
                    case (mode)
                        MODE_SLASH:
                        begin
                            if (c == CH_SLASH)
                            begin
                                mode = MODE_LINE;
                            end
                            else if (c == CH_STAR)
                            begin
                                mode = MODE_BLOCK;
                            end
                            else
                            begin
                                // the held slash was plain text
                                e0_v  = 1'b1;
                                e0    = CH_SLASH;
                                mode  = nr.mode;
                                quote = nr.quote;
                                e1_v  = nr.emit;
                                e1    = c;
                            end
                        end
                        MODE_LINE:
                        begin
                            if (c == CH_NL)
                            begin
                                e0_v = 1'b1;
                                e0   = CH_SPACE;
                                e1_v = 1'b1;
                                e1   = CH_NL;
                                mode = MODE_NORMAL;
                            end
                        end
                        MODE_BLOCK:
                        begin
                            if (c == CH_STAR)
                            begin
                                mode = MODE_STAR;
                            end
                            else if (c == CH_NL)
                            begin
                                rm = 1'b1;
                            end
                        end
                        MODE_STAR:
                        begin
                            if (c == CH_SLASH)
                            begin
                                e0_v = 1'b1;
                                e0   = CH_SPACE;
                                mode = MODE_NORMAL;
                            end
                            else if (c != CH_STAR)
                            begin
                                rm   = (c == CH_NL);
                                mode = MODE_BLOCK;
                            end
                        end
                        MODE_LIT:
                        begin
                            e0_v = 1'b1;
                            e0   = c;
                            if (c == CH_BSLASH)
                            begin
                                mode = MODE_ESC;
                            end
                            else if (c == ((quote == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE))
                            begin
                                mode  = MODE_NORMAL;
                                quote = QUOTE_NONE;
                            end
                        end
                        MODE_ESC:
                        begin
                            e0_v = 1'b1;
                            e0   = c;
                            mode = MODE_LIT;
                        end
                        default:
                        begin
                            mode  = nr.mode;
                            quote = nr.quote;
                            e0_v  = nr.emit;
                            e0    = c;
                        end
                    endcase
                end
                if (rm && n < RES_CNT_BITS'(MAX_RES))
                begin
                    ev[n[RES_IDX_BITS-1:0]] = '{valid: 1'b1, kind: KIND_LINE, ch: CH_NUL};
                    n = n + 1'b1;
                end
                if (e0_v && n < RES_CNT_BITS'(MAX_RES))
                begin
                    ev[n[RES_IDX_BITS-1:0]] = '{valid: 1'b1, kind: KIND_BYTE,
                                                ch: (e0 == CH_NUL) ? CH_SPACE : e0};
                    n = n + 1'b1;
                end
                if (e1_v && n < RES_CNT_BITS'(MAX_RES))
                begin
                    ev[n[RES_IDX_BITS-1:0]] = '{valid: 1'b1, kind: KIND_BYTE,
                                                ch: (e1 == CH_NUL) ? CH_SPACE : e1};
                    n = n + 1'b1;
                end
            end
        end

        // end of text: pending slash or open comment, then the end record
        tail_v = 1'b0;
        tail   = CH_SPACE;
        if (mode == MODE_SLASH)
        begin
            tail_v = 1'b1;
            tail   = CH_SLASH;
        end
        else if (mode == MODE_LINE || mode == MODE_BLOCK || mode == MODE_STAR)
        begin
            tail_v = 1'b1;
        end
        if (flush && tail_v && n < RES_CNT_BITS'(MAX_RES))
        begin
            ev[n[RES_IDX_BITS-1:0]] = '{valid: 1'b1, kind: KIND_BYTE, ch: tail};
            n = n + 1'b1;
        end
        if (flush && n < RES_CNT_BITS'(MAX_RES))
        begin
            ev[n[RES_IDX_BITS-1:0]] = '{valid: 1'b1, kind: KIND_END, ch: CH_NUL};
            n = n + 1'b1;
        end
        ev_count   = n;
        mode_next  = flush ? MODE_NORMAL : mode;
        quote_next = flush ? QUOTE_NONE : quote;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            quote_reg <= QUOTE_NONE;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
        end
    end

endmodule

@@ design/csp_count.sv @@
// Line number and output byte total; stamps removed-newline records with the line and the end record with the total.
module csp_count (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  logic                                    flush,
    input  csp_pkg::event_t  [csp_pkg::MAX_RES-1:0] ev,
    output csp_pkg::result_t [csp_pkg::MAX_RES-1:0] res
);
    import csp_pkg::*;

    logic [LINE_BITS-1:0]    line_reg;
    logic [LINE_BITS-1:0]    line_next;
    logic [COUNT_BITS-1:0]   total_reg;
    logic [COUNT_BITS-1:0]   total_next;
    logic [RES_CNT_BITS-1:0] adv;
    logic [RES_CNT_BITS-1:0] nb;

    always_comb
    begin
        adv = '0;
        nb  = '0;
        res = '0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i].kind = KIND_BYTE;
            if (ev[i].valid)
            begin
                case (ev[i].kind)
                    KIND_BYTE:
                    begin
                        res[i].kind = KIND_BYTE;
                        res[i].ch   = ev[i].ch;
                        nb          = nb + 1'b1;
                        if (ev[i].ch == CH_NL)
                        begin
                            adv = adv + 1'b1;
                        end
                    end
                    KIND_LINE:
                    begin
                        // report the current line, then move past it
                        res[i].kind = KIND_LINE;
                        res[i].line = line_add(line_reg, adv);
                        adv         = adv + 1'b1;
                    end
                    KIND_END:
                    begin
                        res[i].kind  = KIND_END;
                        res[i].count = count_add(total_reg, nb);
                    end
                    default:
                    begin
                        res[i].kind = KIND_BYTE;
                    end
                endcase
            end
        end
        line_next  = flush ? LINE_BITS'(1) : line_add(line_reg, adv);
        total_next = flush ? '0 : count_add(total_reg, nb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= LINE_BITS'(1);
            total_reg <= '0;
        end
        else if (step)
        begin
            line_reg  <= line_next;
            total_reg <= total_next;
        end
    end

endmodule

@@ design/csp_outq.sv @@
// Holds the results of one item and hands them out one beat per cycle while out_stall is low.
module csp_outq (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  csp_pkg::result_t [csp_pkg::MAX_RES-1:0] res,
    input  logic [csp_pkg::RES_CNT_BITS-1:0]        res_count,
    output logic                                    free,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              kind,
    output logic [7:0]                              out_byte,
    output logic [csp_pkg::LINE_BITS-1:0]           line_value,
    output logic [csp_pkg::COUNT_BITS-1:0]          out_count,
    output logic                                    last_of_run
);
    import csp_pkg::*;

    result_t                 slot_reg [MAX_RES];
    logic [RES_CNT_BITS-1:0] n_reg;
    logic [RES_CNT_BITS-1:0] n_next;
    logic [RES_IDX_BITS-1:0] idx_reg;
    logic [RES_IDX_BITS-1:0] idx_next;
    logic [RES_CNT_BITS-1:0] n_less;
    result_t                 cur;
    logic                    take;
    logic                    last;

    assign cur         = slot_reg[idx_reg];
    assign out_valid   = (n_reg != '0);
    assign n_less      = n_reg - 1'b1;
    assign last        = (RES_CNT_BITS'(idx_reg) == n_less);
    assign take        = out_valid && !out_stall;
    assign free        = !out_valid || (take && last);
    assign kind        = cur.kind;
    assign out_byte    = cur.ch;
    assign line_value  = cur.line;
    assign out_count   = cur.count;
    assign last_of_run = last;

    always_comb
    begin
        n_next   = n_reg;
        idx_next = idx_reg;
        if (load)
        begin
            n_next   = res_count;
            idx_next = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                n_next   = '0;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            idx_reg <= '0;
        end
        else
        begin
            n_reg   <= n_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                slot_reg[i] <= res[i];
            end
        end
    end

endmodule

@@ design/c_source_phase_filter_unit.sv @@
// Early C translation phases on a byte stream: trigraphs are replaced, backslash-newline
// splices removed, each comment becomes one space and NUL becomes a space, with literals
// tracked so comment markers inside them stay text. Each input beat may give from zero to
// six result beats (bytes, removed-newline records carrying the line number, and an end
// record with the output byte total after the beat flagged is_final); last_of_run marks
// the final result of a beat. A beat is registered, worked combinationally into a result
// buffer, and drained one result per cycle while out_stall is low, so a new beat is taken
// every cycle while beats give at most one result and the output is not stalled; a beat
// with more results holds the input until the buffer has handed them out. The first result
// is presented once the held beat has been loaded into the result buffer.
module c_source_phase_filter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           is_final,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [7:0]                     out_byte,
    output logic [csp_pkg::LINE_BITS-1:0]  line_value,
    output logic [csp_pkg::COUNT_BITS-1:0] out_count,
    output logic                           last_of_run
);
    import csp_pkg::*;

    logic                     hold_valid_reg;
    logic                     hold_valid_next;
    char_t                    hold_byte_reg;
    logic                     hold_final_reg;
    logic                     accept;
    logic                     step;
    logic                     q_free;
    token_t  [TOK_SLOTS-1:0]  tok;
    event_t  [MAX_RES-1:0]    ev;
    result_t [MAX_RES-1:0]    res;
    logic [RES_CNT_BITS-1:0]  ev_count;

    // a beat with no results never waits for the output buffer
    assign step     = hold_valid_reg && (ev_count == '0 || q_free);
    assign in_stall = hold_valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg  <= in_byte;
            hold_final_reg <= is_final;
        end
    end

    csp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .flush   (hold_final_reg),
        .in_byte (hold_byte_reg),
        .tok     (tok)
    );

    csp_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .flush    (hold_final_reg),
        .tok      (tok),
        .ev       (ev),
        .ev_count (ev_count)
    );

    csp_count u_count (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .flush (hold_final_reg),
        .ev    (ev),
        .res   (res)
    );

    csp_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && ev_count != '0),
        .res         (res),
        .res_count   (ev_count),
        .free        (q_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .line_value  (line_value),
        .out_count   (out_count),
        .last_of_run (last_of_run)
    );

endmodule

@@ test/testbench.sv @@
module testbench;
    import csp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 350;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [2:0] {
        SC_CODE,
        SC_SLASH,
        SC_LINE_CMT,
        SC_BLOCK_CMT,
        SC_BLOCK_STAR,
        SC_LITERAL,
        SC_LIT_ESC
    } scan_t;

    typedef struct packed {
        kind_t                 kind;
        char_t                 ch;
        logic [LINE_BITS-1:0]  line;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } outcome_t;

    typedef struct packed {
        char_t b;
        logic  fin;
    } src_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            in_byte = 8'h00;
    logic                  is_final = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            kind;
    logic [7:0]            out_byte;
    logic [LINE_BITS-1:0]  line_value;
    logic [COUNT_BITS-1:0] out_count;
    logic                  last_of_run;

    c_source_phase_filter_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .is_final    (is_final),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .line_value  (line_value),
        .out_count   (out_count),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    src_beat_t src_q[$];
    outcome_t  due_results[$];
    int        beats_total = 0;
    int        beats_taken = 0;
    int        fail_count = 0;
    int        quiet_cycles = 0;
    logic      in_fire = 1'b0;
    int        idle_left = 0;
    int        calm_left = 0;
    int        stall_left = 0;
    int        free_left = 0;

    // filter state, mirrored per text
    scan_t                 scan_st = SC_CODE;
    char_t                 quote_close = CH_NUL;
    bit                    bs_held = 1'b0;
    int                    q_held = 0;
    logic [LINE_BITS-1:0]  line_no = LINE_BITS'(1);
    logic [COUNT_BITS-1:0] bytes_out = '0;
    outcome_t              run_buf[MAX_RES];
    int                    run_n = 0;

    string tri_from = "()<>=/'!-";
    string tri_to   = "[]{}#\\^|~";

    function automatic void clear_text_state();
        scan_st     = SC_CODE;
        quote_close = CH_NUL;
        bs_held     = 1'b0;
        q_held      = 0;
        line_no     = LINE_BITS'(1);
        bytes_out   = '0;
    endfunction

    function automatic void note(kind_t k, char_t c, logic [LINE_BITS-1:0] ln,
                                 logic [COUNT_BITS-1:0] cnt);
        if (run_n < MAX_RES)
        begin
            run_buf[run_n].kind  = k;
            run_buf[run_n].ch    = c;
            run_buf[run_n].line  = ln;
            run_buf[run_n].count = cnt;
            run_buf[run_n].last  = 1'b0;
            run_n++;
        end
    endfunction

    function automatic void next_line();
        if (line_no != '1)
            line_no++;
    endfunction

    function automatic void put_char(char_t c);
        note(KIND_BYTE, (c == CH_NUL) ? CH_SPACE : c, '0, '0);
        if (bytes_out != '1)
            bytes_out++;
        if (c == CH_NL)
            next_line();
    endfunction

    function automatic void drop_newline();
        note(KIND_LINE, CH_NUL, line_no, '0);
        next_line();
    endfunction

    function automatic void code_char(char_t c);
        if (c == CH_SLASH)
            scan_st = SC_SLASH;
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            quote_close = c;
            scan_st = SC_LITERAL;
            put_char(c);
        end
        else
        begin
            scan_st = SC_CODE;
            put_char(c);
        end
    endfunction

    function automatic void comment_scan(char_t c);
        case (scan_st)
            SC_SLASH:
                if (c == CH_SLASH)
                    scan_st = SC_LINE_CMT;
                else if (c == CH_STAR)
                    scan_st = SC_BLOCK_CMT;
                else
                begin
                    put_char(CH_SLASH);
                    scan_st = SC_CODE;
                    code_char(c);
                end
            SC_LINE_CMT:
                if (c == CH_NL)
                begin
                    put_char(CH_SPACE);
                    scan_st = SC_CODE;
                    put_char(CH_NL);
                end
            SC_BLOCK_CMT:
                if (c == CH_STAR)
                    scan_st = SC_BLOCK_STAR;
                else if (c == CH_NL)
                    drop_newline();
            SC_BLOCK_STAR:
                if (c == CH_SLASH)
                begin
                    put_char(CH_SPACE);
                    scan_st = SC_CODE;
                end
                else if (c != CH_STAR)
                begin
                    if (c == CH_NL)
                        drop_newline();
                    scan_st = SC_BLOCK_CMT;
                end
            SC_LITERAL:
            begin
                put_char(c);
                if (c == CH_BSLASH)
                    scan_st = SC_LIT_ESC;
                else if (c == quote_close)
                begin
                    quote_close = CH_NUL;
                    scan_st = SC_CODE;
                end
            end
            SC_LIT_ESC:
            begin
                put_char(c);
                scan_st = SC_LITERAL;
            end
            default:
                code_char(c);
        endcase
    endfunction

    function automatic void splice_stage(char_t c);
        if (bs_held)
        begin
            bs_held = 1'b0;
            if (c == CH_NL)
            begin
                drop_newline();
                return;
            end
            comment_scan(CH_BSLASH);
        end
        if (c == CH_BSLASH)
            bs_held = 1'b1;
        else
            comment_scan(c);
    endfunction

    // NUL when c does not finish a trigraph
    function automatic char_t tri_target(char_t c);
        for (int i = 0; i < tri_from.len(); i++)
            if (c == char_t'(tri_from[i]))
                return char_t'(tri_to[i]);
        return CH_NUL;
    endfunction

    function automatic void trigraph_stage(char_t c);
        char_t t;
        t = tri_target(c);
        if (q_held >= 2)
        begin
            if (t != CH_NUL)
            begin
                q_held = 0;
                splice_stage(t);
            end
            else if (c == CH_QUEST)
                splice_stage(CH_QUEST);
            else
            begin
                q_held = 0;
                splice_stage(CH_QUEST);
                splice_stage(CH_QUEST);
                splice_stage(c);
            end
        end
        else if (q_held == 1)
        begin
            if (c == CH_QUEST)
                q_held = 2;
            else
            begin
                q_held = 0;
                splice_stage(CH_QUEST);
                splice_stage(c);
            end
        end
        else if (c == CH_QUEST)
            q_held = 1;
        else
            splice_stage(c);
    endfunction

    function automatic void filter_byte(char_t c, logic fin);
        outcome_t res;
        run_n = 0;
        trigraph_stage(c);
        if (fin)
        begin
            while (q_held > 0)
            begin
                q_held--;
                splice_stage(CH_QUEST);
            end
            if (bs_held)
            begin
                bs_held = 1'b0;
                comment_scan(CH_BSLASH);
            end
            if (scan_st == SC_SLASH)
                put_char(CH_SLASH);
            else if (scan_st == SC_LINE_CMT || scan_st == SC_BLOCK_CMT ||
                     scan_st == SC_BLOCK_STAR)
                put_char(CH_SPACE);
            note(KIND_END, CH_NUL, '0, bytes_out);
            clear_text_state();
        end
        for (int i = 0; i < run_n; i++)
        begin
            res = run_buf[i];
            res.last = (i == run_n - 1);
            due_results.push_back(res);
        end
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_byte(char_t b, logic fin);
        src_beat_t s;
        s.b = b;
        s.fin = fin;
        src_q.push_back(s);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(char_t'(s[i]), 1'b0);
    endtask

    task automatic add_fragment();
        case ($urandom_range(0, 15))
            0:
            begin
                add_str("??");
                add_byte(char_t'(tri_from[$urandom_range(0, 8)]), 1'b0);
            end
            1:  add_str("\\\n");
            2:  add_str("??/\n");
            3:  add_str("//");
            4:  add_str("/*");
            5:  add_str("*/");
            6:  add_byte(CH_DQUOTE, 1'b0);
            7:  add_byte(CH_SQUOTE, 1'b0);
            8:  add_byte(CH_BSLASH, 1'b0);
            9:  add_byte(CH_NL, 1'b0);
            10: add_byte(CH_STAR, 1'b0);
            11: add_byte(CH_SLASH, 1'b0);
            12: add_byte(CH_QUEST, 1'b0);
            13: add_byte(char_t'($urandom_range(0, 255)), 1'b0);
            14: add_byte(CH_NUL, 1'b0);
            default: add_byte(char_t'($urandom_range(8'h61, 8'h7A)), 1'b0);
        endcase
    endtask

    task automatic report(string what, outcome_t want, outcome_t got);
        if (fail_count < 10)
        begin
            $display("%s: want kind=%0d byte=%02h line=%0d count=%0d last=%0b",
                     what, want.kind, want.ch, want.line, want.count, want.last);
            $display("%s: got  kind=%0d byte=%02h line=%0d count=%0d last=%0b",
                     what, got.kind, got.ch, got.line, got.count, got.last);
        end
        fail_count++;
    endtask

    // input beat handling, result check and watchdog
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        outcome_t got;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                filter_byte(in_byte, is_final);
                beats_taken++;
            end
            if (out_valid && !out_stall)
            begin
                got.kind  = kind_t'(kind);
                got.ch    = out_byte;
                got.line  = line_value;
                got.count = out_count;
                got.last  = last_of_run;
                if (due_results.size() == 0)
                begin
                    want = '0;
                    report("unexpected result", want, got);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                        report("mismatch", want, got);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        src_beat_t s;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (src_q.size() > 0)
            begin
                s = src_q.pop_front();
                in_byte  <= s.b;
                is_final <= s.fin;
                in_valid <= 1'b1;
                if (calm_left > 0)
                begin
                    calm_left--;
                    idle_left = 0;
                end
                else
                begin
                    idle_left = pick_len();
                    if ($urandom_range(0, 99) < 4)
                        calm_left = $urandom_range(20, 60);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : sink
        if (rst_n)
        begin
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
            else if (free_left > 0)
                free_left--;
            else
            begin
                stall_left = pick_len();
                free_left = ($urandom_range(0, 99) < 10) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 6);
            end
        end
    end

    initial
    begin : stimulus
        int directed;
        int frags;
        clear_text_state();

        // trigraphs, a triple question mark, comment opened across a splice,
        // newline inside a block comment, escaped quote in a literal
        add_str("??(???)");
        add_str("/??/\n*c\n*/");
        add_str("\"//\\\"\"");
        add_byte(CH_NUL, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_str("//x");
        add_byte(CH_QUEST, 1'b1);
        // pending slash, held backslash and held question marks at end of text
        add_str("a");
        add_byte(CH_SLASH, 1'b1);
        add_byte(CH_BSLASH, 1'b1);
        add_str("x?");
        add_byte(CH_QUEST, 1'b1);
        directed = src_q.size();

        while (src_q.size() < directed + RANDOM_BEATS)
        begin
            frags = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                                 : $urandom_range(10, 30);
            for (int i = 0; i < frags; i++)
                add_fragment();
            src_q[src_q.size() - 1].fin = 1'b1;
        end
        beats_total = src_q.size();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        wait (beats_taken == beats_total);
        wait (due_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
